/* src/merge_sorter_macros.svh */
// Assertion macros shared by the merge sorter modules.
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("merge sorter check failed");

// The consequent must hold in the cycle after the antecedent.
`define MS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("merge sorter check failed");

`endif

/* src/ms_pkg.sv */
// Shared constants, types and helpers of the merge sorter.
`timescale 1ns / 1ps

package ms_pkg;

    // Default store capacity and element width.
    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned DATA_W        = 32;

    // Status that the merge engine reports to the top level.
    typedef struct packed {
        logic done;   // one-cycle pulse when the sort has finished
        logic bank;   // bank holding the sorted data: 0 = store, 1 = scratch
    } t_sort_status;

    // Signed less-than on two's complement element words.
    function automatic logic less_signed(input logic [DATA_W-1:0] a,
                                         input logic [DATA_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

/* src/ms_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module ms_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr0,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr1,
    output logic [WIDTH-1:0]                 o_rdata0,
    output logic [WIDTH-1:0]                 o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

/* src/ms_merge.sv */
// Bottom-up merge engine that ping-pongs runs between the two banks.
`timescale 1ns / 1ps
`include "merge_sorter_macros.svh"

module ms_merge #(
    parameter int unsigned MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    i_n,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_raddr0,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_raddr1,
    input  logic [ms_pkg::DATA_W-1:0]         i_rdata0,
    input  logic [ms_pkg::DATA_W-1:0]         i_rdata1,
    output logic                              o_we,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_waddr,
    output logic [ms_pkg::DATA_W-1:0]         o_wdata,
    output ms_pkg::t_sort_status              o_status
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned EW = CW + 2;

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_SEG   = 2'd1;
    localparam logic [1:0] M_PRIME = 2'd2;
    localparam logic [1:0] M_RUN   = 2'd3;

    logic [1:0]                r_state;
    logic                      r_done;
    logic                      r_bank;
    logic [CW-1:0]             r_n;
    logic [CW:0]               r_w;
    logic [CW-1:0]             r_lo;
    logic [CW-1:0]             r_mid;
    logic [CW-1:0]             r_hi;
    logic [CW-1:0]             r_pi;
    logic [CW-1:0]             r_pj;
    logic [CW-1:0]             r_k;
    logic [ms_pkg::DATA_W-1:0] r_head_i;
    logic [ms_pkg::DATA_W-1:0] r_head_j;

    logic [EW-1:0] lo_e;
    logic [EW-1:0] n_e;
    logic [EW-1:0] mid_full;
    logic [EW-1:0] hi_full;
    logic [EW-1:0] w_dbl;
    logic [CW-1:0] seg_mid;
    logic [CW-1:0] seg_hi;
    logic          run_i;
    logic          run_j;
    logic          take_i;
    logic          last_write;
    logic          pass_end;
    logic          pass_final;
    logic [CW-1:0] pi_inc1;
    logic [CW-1:0] pi_inc2;
    logic [CW-1:0] pj_inc1;
    logic [CW-1:0] pj_inc2;

    // Bounds of the next pair of runs, clamped to the element count.
    always_comb begin
        lo_e     = EW'(r_lo);
        n_e      = EW'(r_n);
        mid_full = lo_e + EW'(r_w);
        w_dbl    = EW'(r_w) << 1;
        hi_full  = lo_e + w_dbl;
        seg_mid  = (mid_full < n_e) ? mid_full[CW-1:0] : r_n;
        seg_hi   = (hi_full < n_e) ? hi_full[CW-1:0] : r_n;
    end

    // Merge decision on the two registered run heads.
    always_comb begin
        run_i      = r_pi < r_mid;
        run_j      = r_pj < r_hi;
        take_i     = run_i && (!run_j || ms_pkg::less_signed(r_head_i, r_head_j));
        last_write = ({1'b0, r_k} + (CW+1)'(1)) == {1'b0, r_hi};
        pass_end   = hi_full >= n_e;
        pass_final = w_dbl >= n_e;
        pi_inc1    = r_pi + CW'(1);
        pi_inc2    = r_pi + CW'(2);
        pj_inc1    = r_pj + CW'(1);
        pj_inc2    = r_pj + CW'(2);
    end

    // Read addresses: during a run the port data holds the entry after each head.
    always_comb begin
        case (r_state)
            M_SEG: begin
                o_raddr0 = r_lo[AW-1:0];
                o_raddr1 = seg_mid[AW-1:0];
            end
            M_PRIME: begin
                o_raddr0 = pi_inc1[AW-1:0];
                o_raddr1 = pj_inc1[AW-1:0];
            end
            M_RUN: begin
                o_raddr0 = take_i ? pi_inc2[AW-1:0] : pi_inc1[AW-1:0];
                o_raddr1 = take_i ? pj_inc1[AW-1:0] : pj_inc2[AW-1:0];
            end
            default: begin
                o_raddr0 = r_lo[AW-1:0];
                o_raddr1 = r_mid[AW-1:0];
            end
        endcase
    end

    // One merged element is written to the other bank per run cycle.
    assign o_we     = (r_state == M_RUN);
    assign o_waddr  = r_k[AW-1:0];
    assign o_wdata  = take_i ? r_head_i : r_head_j;
    assign o_status = '{done: r_done, bank: r_bank};

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_bank  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_bank <= 1'b0;
                        if (i_n <= CW'(1)) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= M_SEG;
                        end
                    end
                end
                M_SEG: begin
                    r_state <= M_PRIME;
                end
                M_PRIME: begin
                    r_state <= M_RUN;
                end
                M_RUN: begin
                    if (last_write) begin
                        if (pass_end) begin
                            r_bank <= ~r_bank;
                            if (pass_final) begin
                                r_state <= M_IDLE;
                                r_done  <= 1'b1;
                            end else begin
                                r_state <= M_SEG;
                            end
                        end else begin
                            r_state <= M_SEG;
                        end
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    // Pointers, bounds and run heads.
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_n  <= i_n;
                    r_lo <= '0;
                    r_w  <= (CW+1)'(1);
                end
            end
            M_SEG: begin
                r_mid <= seg_mid;
                r_hi  <= seg_hi;
                r_pi  <= r_lo;
                r_pj  <= seg_mid;
                r_k   <= r_lo;
            end
            M_PRIME: begin
                r_head_i <= i_rdata0;
                r_head_j <= i_rdata1;
            end
            M_RUN: begin
                r_k <= r_k + CW'(1);
                if (take_i) begin
                    r_pi     <= pi_inc1;
                    r_head_i <= i_rdata0;
                end else begin
                    r_pj     <= pj_inc1;
                    r_head_j <= i_rdata1;
                end
                if (last_write) begin
                    if (pass_end) begin
                        r_lo <= '0;
                        r_w  <= w_dbl[CW:0];
                    end else begin
                        r_lo <= hi_full[CW-1:0];
                    end
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // A run cycle always has an element left to take.
    `MS_ASSERT_IMP(a_run_has_head, r_state == M_RUN, run_i || run_j)
    // Writes stay inside the current pair of runs.
    `MS_ASSERT_IMP(a_write_in_seg, r_state == M_RUN, r_k < r_hi)
    // Start only arrives while the engine is idle.
    `MS_ASSERT_IMP(a_start_idle, i_start, r_state == M_IDLE)

endmodule

/* src/merge_sorter.sv */
// Top level of the merge sorter: load, sort control and sorted drain.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_ready    | i_value, i_last
//  output  | out       | o_valid / i_ready    | o_sorted_value, o_last_out, o_overflow
//
// While loading, a beat is taken whenever i_valid is high; the beat marked last
// starts the sort. The sort makes ceil(log2 n) passes through the two banks,
// each pass merging its segments of one or two runs in turn.
// The drain then sends one beat per cycle while i_ready is high.
// Reset is synchronous, active low; the banks are not cleared.
// Input beats are held off during sort and drain; output stalls pause the drain.
`timescale 1ns / 1ps
`include "merge_sorter_macros.svh"

module merge_sorter #(
    parameter int unsigned MAX_ITEMS = ms_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [ms_pkg::DATA_W-1:0]  i_value,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ms_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                              o_last_out,
    output logic                              o_overflow
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned DW = ms_pkg::DATA_W;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SORT  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic [CW-1:0] r_rd_k;
    logic          r_pend;
    logic          r_pend_last;
    logic          r_out_valid;
    logic [DW-1:0] r_out_value;
    logic          r_out_last;
    logic          r_skid_valid;
    logic [DW-1:0] r_skid_value;
    logic          r_skid_last;

    logic          n_out_valid;
    logic          n_skid_valid;

    logic          load_fire;
    logic          has_room;
    logic          store_we;
    logic [CW-1:0] count_after;
    logic          sort_start;
    logic          out_fire;
    logic [1:0]    occ;
    logic          issue;
    logic          rd_last;
    logic          out_free;
    logic          ld_out_skid;
    logic          ld_out_pend;
    logic          ld_skid;

    logic [AW-1:0] mg_raddr0;
    logic [AW-1:0] mg_raddr1;
    logic          mg_we;
    logic [AW-1:0] mg_waddr;
    logic [DW-1:0] mg_wdata;
    logic [DW-1:0] mg_rdata0;
    logic [DW-1:0] mg_rdata1;
    ms_pkg::t_sort_status mg_status;

    logic          sto_we;
    logic [AW-1:0] sto_waddr;
    logic [DW-1:0] sto_wdata;
    logic          scr_we;
    logic [AW-1:0] raddr0;
    logic [DW-1:0] sto_rdata0;
    logic [DW-1:0] sto_rdata1;
    logic [DW-1:0] scr_rdata0;
    logic [DW-1:0] scr_rdata1;
    logic [DW-1:0] land_value;

    // Load side.
    assign o_ready     = (r_state == S_LOAD);
    assign load_fire   = i_valid && o_ready;
    assign has_room    = r_count < CW'(MAX_ITEMS);
    assign store_we    = load_fire && has_room;
    assign count_after = r_count + CW'(has_room);
    assign sort_start  = load_fire && i_last;

    // Drain side: reads are issued only while the output stage has room.
    assign out_fire = r_out_valid && i_ready;
    assign occ      = 2'(r_pend) + 2'(r_out_valid) + 2'(r_skid_valid) - 2'(out_fire);
    assign issue    = (r_state == S_DRAIN) && (r_rd_k < r_count) && (occ < 2'd2);
    assign rd_last  = ({1'b0, r_rd_k} + (CW+1)'(1)) == {1'b0, r_count};

    // Bank routing: both banks share read addresses, the status bank picks the data.
    assign raddr0     = (r_state == S_DRAIN) ? r_rd_k[AW-1:0] : mg_raddr0;
    assign mg_rdata0  = mg_status.bank ? scr_rdata0 : sto_rdata0;
    assign mg_rdata1  = mg_status.bank ? scr_rdata1 : sto_rdata1;
    assign land_value = mg_rdata0;
    assign sto_we     = store_we || (mg_we && mg_status.bank);
    assign sto_waddr  = store_we ? r_count[AW-1:0] : mg_waddr;
    assign sto_wdata  = store_we ? DW'(i_value) : mg_wdata;
    assign scr_we     = mg_we && !mg_status.bank;

    ms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (sto_we),
        .i_waddr  (sto_waddr),
        .i_wdata  (sto_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (mg_raddr1),
        .o_rdata0 (sto_rdata0),
        .o_rdata1 (sto_rdata1)
    );

    ms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_scratch (
        .i_clk    (i_clk),
        .i_we     (scr_we),
        .i_waddr  (mg_waddr),
        .i_wdata  (mg_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (mg_raddr1),
        .o_rdata0 (scr_rdata0),
        .o_rdata1 (scr_rdata1)
    );

    ms_merge #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sort_start),
        .i_n      (count_after),
        .o_raddr0 (mg_raddr0),
        .o_raddr1 (mg_raddr1),
        .i_rdata0 (mg_rdata0),
        .i_rdata1 (mg_rdata1),
        .o_we     (mg_we),
        .o_waddr  (mg_waddr),
        .o_wdata  (mg_wdata),
        .o_status (mg_status)
    );

    // Output register and skid stage steering.
    always_comb begin
        out_free     = out_fire || !r_out_valid;
        ld_out_skid  = out_free && r_skid_valid;
        ld_out_pend  = out_free && !r_skid_valid && r_pend;
        ld_skid      = r_pend && !ld_out_pend;
        n_out_valid  = out_free ? (r_skid_valid || r_pend) : 1'b1;
        n_skid_valid = out_free ? (r_skid_valid && r_pend) : (r_skid_valid || r_pend);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_dropped    <= 1'b0;
            r_rd_k       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_pend       <= issue;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            case (r_state)
                S_LOAD: begin
                    if (load_fire) begin
                        r_count <= count_after;
                        if (!has_room) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= S_SORT;
                        end
                    end
                end
                S_SORT: begin
                    if (mg_status.done) begin
                        r_state <= S_DRAIN;
                        r_rd_k  <= '0;
                    end
                end
                S_DRAIN: begin
                    if (issue) begin
                        r_rd_k <= r_rd_k + CW'(1);
                    end
                    if (out_fire && r_out_last) begin
                        r_state   <= S_LOAD;
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last <= rd_last;
        end
        if (ld_out_skid) begin
            r_out_value <= r_skid_value;
            r_out_last  <= r_skid_last;
        end else if (ld_out_pend) begin
            r_out_value <= land_value;
            r_out_last  <= r_pend_last;
        end
        if (ld_skid) begin
            r_skid_value <= land_value;
            r_skid_last  <= r_pend_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = $signed(r_out_value);
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_dropped;

    // No result is presented while a set is still loading.
    `MS_ASSERT_IMP(a_no_out_in_load, r_state == S_LOAD, !r_out_valid)
    // A read in flight always finds the skid stage empty.
    `MS_ASSERT_IMP(a_pend_no_skid, r_pend, !r_skid_valid)
    // The fill count never passes the store capacity.
    `MS_ASSERT_IMP(a_count_cap, r_state != S_DRAIN, r_count <= CW'(MAX_ITEMS))
    // The final beat returns the block to an empty load.
    `MS_ASSERT_NEXT(a_set_closes, out_fire && r_out_last, r_state == S_LOAD && r_count == '0)

endmodule
